// ===== design/binary_min_heap_unit_macros.svh =====
// Assertion macros shared by the heap unit checker.
`ifndef BINARY_MIN_HEAP_UNIT_MACROS_SVH
`define BINARY_MIN_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bmh_pkg.sv =====
`default_nettype none
package bmh_pkg;

  // Fixed field widths of the stream words.
  localparam int MODE_BITS          = 3;
  localparam int IN_VALUE_BITS      = 32;
  localparam int OUT_VALUE_BITS     = 32;
  localparam int OUT_COUNT_BITS     = 7;
  localparam int S_TDATA_BITS       = 32;
  localparam int S_TUSER_BITS       = 3;
  localparam int M_TDATA_BITS       = 40;
  localparam int M_TUSER_BITS       = 2;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 64;
  localparam int VALUE_BITS_DEFAULT = 32;

  // Operation codes carried in the input word.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_BUILD  = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_START,
    ST_DN_LOAD,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP_R,
    ST_DN_MOVE,
    ST_RO_RD,
    ST_RO_OUT,
    ST_RESP,
    ST_RESP_FULL
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_APPEND,
    DP_CLEAR,
    DP_BUILD_INIT,
    DP_UP_RD,
    DP_UP_FIN,
    DP_UP_STEP,
    DP_DN_START,
    DP_DN_LOAD,
    DP_DN_RD_L,
    DP_DN_RD_R,
    DP_DN_CMP_R,
    DP_DN_MOVE,
    DP_RO_INIT,
    DP_RO_RD,
    DP_RO_STEP
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   out_load;   // load the result register
    logic   out_entry;  // result carries a store entry
    logic   out_full;   // status result reports a dropped value
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic bi_zero;
    logic dn_stay;
    logic ro_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/bmh_ctrl.sv =====
`default_nettype none
module bmh_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic [bmh_pkg::MODE_BITS-1:0]   in_mode,
  output logic                                 in_ready,
  input  wire bmh_pkg::stat_t                  stat,
  output bmh_pkg::cmd_t                        cmd
);

  bmh_pkg::state_t state, state_next;
  bmh_pkg::mode_t  mode;

  assign mode     = bmh_pkg::mode_t'(in_mode);
  assign in_ready = (state == bmh_pkg::ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cmd.op        = bmh_pkg::DP_NOP;
    cmd.out_load  = 1'b0;
    cmd.out_entry = 1'b0;
    cmd.out_full  = 1'b0;
    unique case (state)
      bmh_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            bmh_pkg::MODE_INSERT: begin
              if (stat.full) begin
                state_next = bmh_pkg::ST_RESP_FULL;
              end else begin
                cmd.op     = bmh_pkg::DP_APPEND;
                state_next = bmh_pkg::ST_UP_RD;
              end
            end
            bmh_pkg::MODE_APPEND: begin
              if (stat.full) begin
                state_next = bmh_pkg::ST_RESP_FULL;
              end else begin
                cmd.op     = bmh_pkg::DP_APPEND;
                state_next = bmh_pkg::ST_RESP;
              end
            end
            bmh_pkg::MODE_BUILD: begin
              cmd.op     = bmh_pkg::DP_BUILD_INIT;
              state_next = bmh_pkg::ST_DN_START;
            end
            bmh_pkg::MODE_CLEAR: begin
              cmd.op     = bmh_pkg::DP_CLEAR;
              state_next = bmh_pkg::ST_RESP;
            end
            bmh_pkg::MODE_READ: begin
              if (stat.empty) begin
                state_next = bmh_pkg::ST_RESP;
              end else begin
                cmd.op     = bmh_pkg::DP_RO_INIT;
                state_next = bmh_pkg::ST_RO_RD;
              end
            end
            default: begin
              state_next = bmh_pkg::ST_RESP;
            end
          endcase
        end
      end
      // Sift up: fetch the parent, then move it down or settle.
      bmh_pkg::ST_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.op     = bmh_pkg::DP_UP_FIN;
          state_next = bmh_pkg::ST_RESP;
        end else begin
          cmd.op     = bmh_pkg::DP_UP_RD;
          state_next = bmh_pkg::ST_UP_CMP;
        end
      end
      bmh_pkg::ST_UP_CMP: begin
        if (stat.up_less) begin
          cmd.op     = bmh_pkg::DP_UP_STEP;
          state_next = bmh_pkg::ST_UP_RD;
        end else begin
          cmd.op     = bmh_pkg::DP_UP_FIN;
          state_next = bmh_pkg::ST_RESP;
        end
      end
      // Build: one sift-down per inner node, last inner node first.
      bmh_pkg::ST_DN_START: begin
        if (stat.bi_zero) begin
          state_next = bmh_pkg::ST_RESP;
        end else begin
          cmd.op     = bmh_pkg::DP_DN_START;
          state_next = bmh_pkg::ST_DN_LOAD;
        end
      end
      bmh_pkg::ST_DN_LOAD: begin
        cmd.op     = bmh_pkg::DP_DN_LOAD;
        state_next = bmh_pkg::ST_DN_RD_L;
      end
      bmh_pkg::ST_DN_RD_L: begin
        cmd.op     = bmh_pkg::DP_DN_RD_L;
        state_next = bmh_pkg::ST_DN_RD_R;
      end
      bmh_pkg::ST_DN_RD_R: begin
        cmd.op     = bmh_pkg::DP_DN_RD_R;
        state_next = bmh_pkg::ST_DN_CMP_R;
      end
      bmh_pkg::ST_DN_CMP_R: begin
        cmd.op     = bmh_pkg::DP_DN_CMP_R;
        state_next = bmh_pkg::ST_DN_MOVE;
      end
      bmh_pkg::ST_DN_MOVE: begin
        cmd.op     = bmh_pkg::DP_DN_MOVE;
        state_next = stat.dn_stay ? bmh_pkg::ST_DN_START : bmh_pkg::ST_DN_RD_L;
      end
      // Read out: one store read, then one word per entry.
      bmh_pkg::ST_RO_RD: begin
        cmd.op     = bmh_pkg::DP_RO_RD;
        state_next = bmh_pkg::ST_RO_OUT;
      end
      bmh_pkg::ST_RO_OUT: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          if (stat.ro_last) begin
            state_next = bmh_pkg::ST_IDLE;
          end else begin
            cmd.op     = bmh_pkg::DP_RO_STEP;
            state_next = bmh_pkg::ST_RO_RD;
          end
        end
      end
      bmh_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bmh_pkg::ST_IDLE;
        end
      end
      bmh_pkg::ST_RESP_FULL: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_full = 1'b1;
          state_next   = bmh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bmh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/bmh_dp.sv =====
`default_nettype none
module bmh_dp #(
  parameter int DEPTH      = bmh_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = bmh_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic signed [bmh_pkg::IN_VALUE_BITS-1:0] in_value,
  input  wire bmh_pkg::cmd_t                            cmd,
  output bmh_pkg::stat_t                                stat,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  output logic signed [bmh_pkg::OUT_VALUE_BITS-1:0]     out_value,
  output logic                                          out_valid,
  output logic [bmh_pkg::OUT_COUNT_BITS-1:0]            out_count,
  output logic                                          out_status,
  output logic                                          out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  // Entry store with one write and one registered read port.
  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic signed [VALUE_BITS-1:0] wr_data, rd_data;

  // Working registers.
  logic [CW-1:0]                count;
  logic [CW-1:0]                bi;
  logic [AW-1:0]                pos, best_pos, ro;
  logic signed [VALUE_BITS-1:0] hold, best;

  logic signed [VALUE_BITS-1:0] in_v;
  logic [AW-1:0]                pos_m1, parent, bi_pos;
  logic [IW-1:0]                l_idx, r_idx, count_w;
  logic                         l_ok, r_ok;

  assign in_v    = VALUE_BITS'(in_value);
  assign pos_m1  = pos - AW'(1);
  assign parent  = AW'(pos_m1 >> 1);
  assign bi_pos  = AW'(bi - CW'(1));
  assign l_idx   = IW'({pos, 1'b1});
  assign r_idx   = l_idx + IW'(1);
  assign count_w = IW'(count);
  assign l_ok    = (l_idx < count_w);
  assign r_ok    = (r_idx < count_w);

  // Status toward the controller.
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.pos_zero = (pos == '0);
  assign stat.up_less  = (hold < rd_data);
  assign stat.bi_zero  = (bi == '0);
  assign stat.dn_stay  = (best_pos == pos);
  assign stat.ro_last  = ((CW'(ro) + CW'(1)) == count);
  assign stat.out_free = !out_tvalid || out_tready;

  // Store port control per operation.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    rd_en   = 1'b0;
    rd_addr = pos;
    unique case (cmd.op)
      bmh_pkg::DP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count);
        wr_data = in_v;
      end
      bmh_pkg::DP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent;
      end
      bmh_pkg::DP_UP_FIN: begin
        wr_en = 1'b1;
      end
      bmh_pkg::DP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      bmh_pkg::DP_DN_START: begin
        rd_en   = 1'b1;
        rd_addr = bi_pos;
      end
      bmh_pkg::DP_DN_RD_L: begin
        rd_en   = 1'b1;
        rd_addr = l_idx[AW-1:0];
      end
      bmh_pkg::DP_DN_RD_R: begin
        rd_en   = 1'b1;
        rd_addr = r_idx[AW-1:0];
      end
      bmh_pkg::DP_DN_MOVE: begin
        wr_en   = 1'b1;
        wr_data = (best_pos == pos) ? hold : best;
      end
      bmh_pkg::DP_RO_RD: begin
        rd_en   = 1'b1;
        rd_addr = ro;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry count, cleared by reset and by a clear operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == bmh_pkg::DP_APPEND) begin
      count <= count + CW'(1);
    end else if (cmd.op == bmh_pkg::DP_CLEAR) begin
      count <= '0;
    end
  end

  // Sift and read-out registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bmh_pkg::DP_APPEND: begin
        hold <= in_v;
        pos  <= AW'(count);
      end
      bmh_pkg::DP_BUILD_INIT: begin
        bi <= count >> 1;
      end
      bmh_pkg::DP_UP_STEP: begin
        pos <= parent;
      end
      bmh_pkg::DP_DN_START: begin
        pos <= bi_pos;
      end
      bmh_pkg::DP_DN_LOAD: begin
        hold     <= rd_data;
        best     <= rd_data;
        best_pos <= pos;
      end
      bmh_pkg::DP_DN_RD_R: begin
        if (l_ok && (rd_data < best)) begin
          best     <= rd_data;
          best_pos <= l_idx[AW-1:0];
        end
      end
      bmh_pkg::DP_DN_CMP_R: begin
        if (r_ok && (rd_data < best)) begin
          best     <= rd_data;
          best_pos <= r_idx[AW-1:0];
        end
      end
      bmh_pkg::DP_DN_MOVE: begin
        if (best_pos == pos) begin
          bi <= bi - CW'(1);
        end else begin
          pos  <= best_pos;
          best <= hold;
        end
      end
      bmh_pkg::DP_RO_INIT: begin
        ro <= '0;
      end
      bmh_pkg::DP_RO_STEP: begin
        ro <= ro + AW'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register; it frees itself when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count <= bmh_pkg::OUT_COUNT_BITS'(count);
      if (cmd.out_entry) begin
        out_value  <= bmh_pkg::OUT_VALUE_BITS'(rd_data);
        out_valid  <= 1'b1;
        out_status <= 1'b0;
        out_last   <= stat.ro_last;
      end else begin
        out_value  <= '0;
        out_valid  <= 1'b0;
        out_status <= cmd.out_full;
        out_last   <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/binary_min_heap_unit.sv =====
// Insert: the value is appended, then rises one level per parent fetch while it is smaller.
// Build: one sift-down per inner node, from the last inner node back to the root.
// Read out: each entry is read from the store before it is sent, one word per entry.
// Other items go straight to their result word, which waits on a stalled word. One item is
// worked on at a time; the result register lets the next item in while the last word waits.
// Reset empties the store (count to zero) at once; the store itself is not cleared.
`default_nettype none
module binary_min_heap_unit #(
  parameter int DEPTH      = bmh_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = bmh_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [bmh_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [31:0] in_value
  input  wire logic [bmh_pkg::S_TUSER_BITS-1:0]  s_tuser,  // [2:0] mode
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [bmh_pkg::M_TDATA_BITS-1:0]       m_tdata,  // [31:0] out_value, [38:32] out_count
  output logic [bmh_pkg::M_TUSER_BITS-1:0]       m_tuser,  // [0] out_valid, [1] out_status
  output logic                                   m_tlast
);

  bmh_pkg::cmd_t  cmd;
  bmh_pkg::stat_t stat;

  logic signed [bmh_pkg::OUT_VALUE_BITS-1:0] out_value;
  logic [bmh_pkg::OUT_COUNT_BITS-1:0]        out_count;
  logic                                      out_valid, out_status;

  bmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmh_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_tvalid),
    .out_tready (m_tready),
    .out_value  (out_value),
    .out_valid  (out_valid),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  // Pack the result word.
  assign m_tdata = {1'b0, out_count, out_value};
  assign m_tuser = {out_status, out_valid};

endmodule
`default_nettype wire

// ===== design/bmh_checker.sv =====
`default_nettype none
`include "binary_min_heap_unit_macros.svh"
module bmh_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [bmh_pkg::S_TDATA_BITS-1:0] s_tdata,
  input wire logic [bmh_pkg::S_TUSER_BITS-1:0] s_tuser,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [bmh_pkg::M_TDATA_BITS-1:0] m_tdata,
  input wire logic [bmh_pkg::M_TUSER_BITS-1:0] m_tuser,
  input wire logic                             m_tlast
);

  // A stalled result word holds still.
  `BMH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

  // A word without an entry carries a zero value and ends its item.
  `BMH_ASSERT_NOW(a_status_word, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0 && m_tlast, "status word malformed")

  // A dropped value is reported only on a status word.
  `BMH_ASSERT_NOW(a_full_flag, m_tvalid && m_tuser[1], !m_tuser[0] && m_tlast, "full flag on an entry word")

  // The unit is busy in the cycle after it takes an item.
  `BMH_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready, "second item taken back to back")

endmodule

bind binary_min_heap_unit bmh_checker u_bmh_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmh_pkg::*;

  localparam int HEAP_DEPTH  = DEPTH_DEFAULT;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 100;

  // One result word as the block should send it.
  typedef struct {
    logic signed [OUT_VALUE_BITS-1:0] value;
    logic                             valid;
    logic [OUT_COUNT_BITS-1:0]        count;
    logic                             status;
    logic                             last;
  } heap_word_t;

  // Tracks the heap contents and the words each accepted operation should produce.
  class heap_tracker;
    logic signed [IN_VALUE_BITS-1:0] heap_vals [HEAP_DEPTH];
    int                              heap_len;
    heap_word_t                      pending_words[$];
    int                              errors;

    function new();
      heap_len = 0;
      errors   = 0;
    endfunction

    function void push_word(logic signed [31:0] value, logic valid, logic status,
                            logic last);
      heap_word_t w;
      w.value  = value;
      w.valid  = valid;
      w.count  = heap_len[OUT_COUNT_BITS-1:0];
      w.status = status;
      w.last   = last;
      pending_words.insert(pending_words.size(), w);
    endfunction

    function void swap_vals(int a, int b);
      logic signed [IN_VALUE_BITS-1:0] t;
      t            = heap_vals[a];
      heap_vals[a] = heap_vals[b];
      heap_vals[b] = t;
    endfunction

    // Moves the entry at p down while a child is strictly smaller; left wins ties.
    function void sift_down(int p);
      int least;
      int l;
      int r;
      while (1) begin
        least = p;
        l     = 2 * p + 1;
        r     = 2 * p + 2;
        if (l < heap_len && heap_vals[l] < heap_vals[least]) least = l;
        if (r < heap_len && heap_vals[r] < heap_vals[least]) least = r;
        if (least == p) break;
        swap_vals(p, least);
        p = least;
      end
    endfunction

    // Applies one accepted operation and queues the words it causes.
    function void note_op(logic [MODE_BITS-1:0] op, logic [IN_VALUE_BITS-1:0] value);
      logic status;
      int   p;
      int   parent;
      status = 1'b0;
      case (op)
        MODE_INSERT, MODE_APPEND: begin
          if (heap_len >= HEAP_DEPTH) begin
            status = 1'b1;
          end else begin
            p            = heap_len;
            heap_vals[p] = value;
            heap_len++;
            if (op == MODE_INSERT) begin
              while (p > 0) begin
                parent = (p - 1) / 2;
                if (!(heap_vals[p] < heap_vals[parent])) break;
                swap_vals(p, parent);
                p = parent;
              end
            end
          end
        end
        MODE_BUILD: begin
          for (p = heap_len / 2; p > 0; p--) sift_down(p - 1);
        end
        MODE_CLEAR: begin
          heap_len = 0;
        end
        MODE_READ: begin
          if (heap_len == 0) begin
            push_word('0, 1'b0, 1'b0, 1'b1);
          end else begin
            for (p = 0; p < heap_len; p++)
              push_word(heap_vals[p], 1'b1, 1'b0, p == heap_len - 1);
          end
          return;
        end
        default: begin
        end
      endcase
      push_word('0, 1'b0, status, 1'b1);
    endfunction

    // Compares one accepted output word with the oldest expected word.
    function void check_word(logic [M_TDATA_BITS-1:0] tdata, logic [M_TUSER_BITS-1:0] tuser,
                             logic tlast);
      heap_word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected word: tdata %h tuser %b tlast %b", tdata, tuser, tlast);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      if (tdata[31:0] !== w.value) begin
        $error("out_value: expected %0d, got %0d", w.value, $signed(tdata[31:0]));
        errors++;
      end
      if (tdata[38:32] !== w.count) begin
        $error("out_count: expected %0d, got %0d", w.count, tdata[38:32]);
        errors++;
      end
      if (tuser[0] !== w.valid) begin
        $error("out_valid: expected %0b, got %0b", w.valid, tuser[0]);
        errors++;
      end
      if (tuser[1] !== w.status) begin
        $error("out_status: expected %0b, got %0b", w.status, tuser[1]);
        errors++;
      end
      if (tlast !== w.last) begin
        $error("out_last: expected %0b, got %0b", w.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata;   // [31:0] in_value
  logic [S_TUSER_BITS-1:0] s_tuser;   // [2:0] mode
  logic                    m_tvalid;
  logic                    m_tready;
  logic [M_TDATA_BITS-1:0] m_tdata;   // [31:0] out_value, [38:32] out_count
  logic [M_TUSER_BITS-1:0] m_tuser;   // [0] out_valid, [1] out_status
  logic                    m_tlast;

  heap_tracker tracker = new();
  bit          idle_on   = 1'b1;
  bit          hold_sink = 1'b0;

  binary_min_heap_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Offers one word, after an optional idle burst, and waits for it to be taken.
  task automatic send_op(logic [MODE_BITS-1:0] op, logic [IN_VALUE_BITS-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_op(op, value);
  endtask

  // Holds the input idle until every expected word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
  endtask

  // Values that favor the extremes and small numbers that produce ties.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 7) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return MODE_INSERT;
    if (roll < 60) return MODE_APPEND;
    if (roll < 70) return MODE_BUILD;
    if (roll < 82) return MODE_READ;
    if (roll < 90) return MODE_CLEAR;
    return 3'($urandom_range(5, 7));
  endfunction

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_sink = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every accepted output word is checked.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_word(m_tdata, m_tuser, m_tlast);
  end

  // Stimulus.
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every operation, ties, unused modes, empty read out.
    send_op(MODE_READ,   32'h0);
    send_op(MODE_INSERT, 32'h7FFF_FFFF);
    send_op(MODE_INSERT, 32'h8000_0000);
    send_op(MODE_INSERT, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 32'h0);
    send_op(MODE_INSERT, 32'h1);
    send_op(MODE_INSERT, 32'h1);
    send_op(MODE_APPEND, 32'd5);
    send_op(MODE_APPEND, -32'sd7);
    send_op(MODE_READ,   32'h0);
    send_op(MODE_BUILD,  32'h0);
    send_op(MODE_READ,   32'h0);
    send_op(3'd5,        32'hAAAA_AAAA);
    send_op(3'd6,        32'h5555_5555);
    send_op(3'd7,        32'h0);
    send_op(MODE_CLEAR,  32'h0);
    send_op(MODE_READ,   32'h0);
    send_op(MODE_APPEND, 32'd9);
    send_op(MODE_APPEND, 32'd3);
    send_op(MODE_APPEND, 32'd3);
    send_op(MODE_BUILD,  32'h0);
    send_op(MODE_READ,   32'h0);
    send_op(MODE_INSERT, 32'hAAAA_AAAA);
    send_op(MODE_APPEND, 32'h5555_5555);
    send_op(MODE_CLEAR,  32'h0);
    wait_drained();

    // Fill the store, overflow it, then order and read it back.
    while (tracker.heap_len < HEAP_DEPTH)
      send_op($urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND, pick_value());
    send_op(MODE_INSERT, pick_value());
    send_op(MODE_APPEND, pick_value());
    send_op(MODE_READ,   pick_value());
    send_op(MODE_BUILD,  pick_value());
    send_op(MODE_INSERT, pick_value());
    send_op(MODE_READ,   pick_value());
    send_op(MODE_CLEAR,  pick_value());
    wait_drained();

    // The receiver holds off while words keep coming, so the input stalls.
    hold_sink = 1'b1;
    for (int i = 0; i < 8; i++)
      send_op(i == 5 ? MODE_READ : MODE_INSERT, pick_value());
    wait_drained();

    // Random mix; the final stretch runs without any idling.
    for (int i = 0; i < 8; i++) begin
      if (i == 4) idle_on = 1'b0;
      send_op(pick_mode(), pick_value());
    end
    send_op(MODE_READ, 32'h0);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("** binary_min_heap_unit: PASSED **");
    end else begin
      $display("** binary_min_heap_unit: FAILED **");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("** binary_min_heap_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/bmh_pkg.sv
design/bmh_ctrl.sv
design/bmh_dp.sv
design/binary_min_heap_unit.sv
design/bmh_checker.sv
tb/sv/testbench.sv
